@@ rtl/dqe_pkg.sv @@
package dqe_pkg;

  localparam int IDW          = 10;
  localparam int ID_COUNT_DEF = 1024;
  localparam int WORD_W       = 32;
  localparam int WB           = 5;

  typedef enum logic [1:0] {
    KIND_PUSH   = 2'd0,
    KIND_POP    = 2'd1,
    KIND_CHANGE = 2'd2
  } kind_t;

  typedef enum logic [1:0] {
    ORD_UNORDERED = 2'd0,
    ORD_FIFO      = 2'd1,
    ORD_LIFO      = 2'd2
  } order_t;

  typedef struct packed {
    logic [1:0]     kind;
    logic [IDW-1:0] item_id;
    logic [1:0]     new_order;
  } in_item_t;

  typedef struct packed {
    logic           inserted;
    logic           popped_valid;
    logic [IDW-1:0] popped_id;
    logic           empty_pop_error;
    logic           has_next;
  } out_item_t;

  typedef enum logic [3:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_DISPATCH,
    ST_POP_COMMIT,
    ST_SCAN_CHECK,
    ST_RB_LOAD,
    ST_RB_BIT
  } state_t;

  typedef enum logic [3:0] {
    CMD_HOLD,
    CMD_CLEAR,
    CMD_ACCEPT,
    CMD_PUSH,
    CMD_POP_EMPTY,
    CMD_POP_FETCH,
    CMD_POP_COMMIT,
    CMD_SCAN_START,
    CMD_SCAN_NEXT,
    CMD_SCAN_COMMIT,
    CMD_CHANGE,
    CMD_RB_START,
    CMD_RB_LOAD,
    CMD_RB_WRITE,
    CMD_RB_NEXT,
    CMD_RB_FINISH
  } cmd_t;

  typedef struct packed {
    logic [1:0] kind;
    logic       in_fire;
    logic       cnt_zero;
    logic       unordered;
    logic       rebuild;
    logic       row_hit;
    logic       word_zero;
    logic       last_row;
    logic       out_free;
  } dqe_status_t;

  // lowest set bit of a bitmap word
  function automatic logic [WB-1:0] lowest_bit(input logic [WORD_W-1:0] w);
    logic [WB-1:0] b;
    b = '0;
    for (int i = WORD_W - 1; i >= 0; i--) begin
      if (w[i]) begin
        b = WB'(i);
      end
    end
    return b;
  endfunction

endpackage

@@ rtl/dqe_ram.sv @@
module dqe_ram #(
  parameter int W = 8,
  parameter int D = 16
) (
  input  logic                         clk,
  input  logic                         we,
  input  logic [(D > 1 ? $clog2(D) : 1)-1:0] waddr,
  input  logic [W-1:0]                 wdata,
  input  logic [(D > 1 ? $clog2(D) : 1)-1:0] raddr,
  output logic [W-1:0]                 rdata
);

  logic [W-1:0] mem [D];
  logic [W-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_r <= mem[raddr];
  end

  assign rdata = rdata_r;

endmodule

@@ rtl/dqe_ctrl.sv @@
module dqe_ctrl
  import dqe_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  dqe_status_t st,
  output cmd_t        cmd
);

  state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_CLEAR;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_CLEAR: if (st.last_row) state_nxt = ST_IDLE;
      ST_IDLE:  if (st.in_fire) state_nxt = ST_DISPATCH;
      ST_DISPATCH: begin
        unique case (st.kind)
          KIND_PUSH: if (st.out_free) state_nxt = ST_IDLE;
          KIND_POP: begin
            if (st.cnt_zero) begin
              if (st.out_free) state_nxt = ST_IDLE;
            end else if (st.unordered) begin
              state_nxt = ST_SCAN_CHECK;
            end else begin
              state_nxt = ST_POP_COMMIT;
            end
          end
          default: begin
            if (st.rebuild) state_nxt = ST_RB_LOAD;
            else if (st.out_free) state_nxt = ST_IDLE;
          end
        endcase
      end
      ST_POP_COMMIT: if (st.out_free) state_nxt = ST_IDLE;
      ST_SCAN_CHECK: if (st.row_hit && st.out_free) state_nxt = ST_IDLE;
      ST_RB_LOAD:    state_nxt = ST_RB_BIT;
      ST_RB_BIT: begin
        if (st.word_zero) begin
          if (!st.last_row) state_nxt = ST_RB_LOAD;
          else if (st.out_free) state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_comb begin
    cmd = CMD_HOLD;
    unique case (state_r)
      ST_CLEAR: cmd = CMD_CLEAR;
      ST_IDLE:  cmd = CMD_ACCEPT;
      ST_DISPATCH: begin
        unique case (st.kind)
          KIND_PUSH: if (st.out_free) cmd = CMD_PUSH;
          KIND_POP: begin
            if (st.cnt_zero) begin
              if (st.out_free) cmd = CMD_POP_EMPTY;
            end else if (st.unordered) begin
              cmd = CMD_SCAN_START;
            end else begin
              cmd = CMD_POP_FETCH;
            end
          end
          default: begin
            if (st.rebuild) cmd = CMD_RB_START;
            else if (st.out_free) cmd = CMD_CHANGE;
          end
        endcase
      end
      ST_POP_COMMIT: if (st.out_free) cmd = CMD_POP_COMMIT;
      ST_SCAN_CHECK: begin
        if (!st.row_hit) cmd = CMD_SCAN_NEXT;
        else if (st.out_free) cmd = CMD_SCAN_COMMIT;
      end
      ST_RB_LOAD: cmd = CMD_RB_LOAD;
      ST_RB_BIT: begin
        if (!st.word_zero) cmd = CMD_RB_WRITE;
        else if (!st.last_row) cmd = CMD_RB_NEXT;
        else if (st.out_free) cmd = CMD_RB_FINISH;
      end
      default: cmd = CMD_HOLD;
    endcase
  end

endmodule

@@ rtl/dqe_datapath.sv @@
module dqe_datapath
  import dqe_pkg::*;
#(
  parameter int ID_COUNT = ID_COUNT_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  input  cmd_t        cmd,
  output dqe_status_t st,
  input  logic        in_valid,
  output logic        in_ready,
  input  in_item_t    in_data,
  output logic        out_valid,
  input  logic        out_ready,
  output out_item_t   out_data
);

  localparam int IW   = $clog2(ID_COUNT);
  localparam int CW   = $clog2(ID_COUNT + 1);
  localparam int ROWS = (ID_COUNT + WORD_W - 1) / WORD_W;
  localparam int RW   = (ROWS > 1) ? $clog2(ROWS) : 1;

  logic [1:0]     kind_r;
  logic [1:0]     req_r;
  logic [IDW-1:0] id_r, id_nxt;
  logic [RW-1:0]  arow_r, arow_nxt;
  logic [IW-1:0]  head_r, head_nxt;
  logic [CW-1:0]  cnt_r, cnt_nxt;
  order_t         order_r, order_nxt;
  logic [IW-1:0]  wptr_r, wptr_nxt;
  logic [WORD_W-1:0] word_r, word_nxt;
  out_item_t      out_r, out_nxt;
  logic           out_valid_r, out_valid_nxt;
  logic           emit;

  logic              bm_we;
  logic [WORD_W-1:0] bm_wdata, bm_rdata;
  logic              os_we;
  logic [IW-1:0]     os_waddr, os_raddr;
  logic [IDW-1:0]    os_wdata, os_rdata;

  logic [CW:0]   sum, sum_m1, tail_w, tail_m1_w;
  logic [IW:0]   head_inc;
  logic [IW-1:0] tail_idx, tail_m1_idx, head_adv;
  logic          in_fire, out_free;
  logic [RW-1:0] in_row, os_row;
  logic [WB-1:0] scan_bit, rb_bit;
  logic [WORD_W-1:0] id_mask;
  logic          id_ok, present;
  logic          req_ok;

  assign in_fire  = (cmd == CMD_ACCEPT) && in_valid;
  assign in_ready = (cmd == CMD_ACCEPT);
  assign out_free = !out_valid_r || out_ready;

  assign in_row  = RW'(32'(in_data.item_id) >> WB);
  assign os_row  = RW'(32'(os_rdata) >> WB);
  assign id_mask = WORD_W'(1) << id_r[WB-1:0];
  assign id_ok   = 32'(id_r) < ID_COUNT;
  assign present = |(bm_rdata & id_mask);
  assign req_ok  = (req_r == ORD_UNORDERED) || (req_r == ORD_FIFO) || (req_r == ORD_LIFO);
  assign scan_bit = lowest_bit(bm_rdata);
  assign rb_bit   = lowest_bit(word_r);

  // circular deque positions
  assign sum       = (CW+1)'(head_r) + (CW+1)'(cnt_r);
  assign sum_m1    = sum - (CW+1)'(1);
  assign tail_w    = (sum >= (CW+1)'(ID_COUNT)) ? sum - (CW+1)'(ID_COUNT) : sum;
  assign tail_m1_w = (sum_m1 >= (CW+1)'(ID_COUNT)) ? sum_m1 - (CW+1)'(ID_COUNT) : sum_m1;
  assign tail_idx    = tail_w[IW-1:0];
  assign tail_m1_idx = tail_m1_w[IW-1:0];
  assign head_inc  = (IW+1)'(head_r) + (IW+1)'(1);
  assign head_adv  = (head_inc >= (IW+1)'(ID_COUNT)) ? IW'(0) : head_inc[IW-1:0];
  assign os_raddr  = (order_r == ORD_LIFO) ? tail_m1_idx : head_r;

  always_comb begin
    arow_nxt  = arow_r;
    id_nxt    = id_r;
    head_nxt  = head_r;
    cnt_nxt   = cnt_r;
    order_nxt = order_r;
    wptr_nxt  = wptr_r;
    word_nxt  = word_r;
    bm_we     = 1'b0;
    bm_wdata  = '0;
    os_we     = 1'b0;
    os_waddr  = tail_idx;
    os_wdata  = id_r;
    emit      = 1'b0;
    out_nxt   = '0;
    case (cmd)
      CMD_CLEAR: begin
        bm_we    = 1'b1;
        arow_nxt = arow_r + RW'(1);
      end
      CMD_ACCEPT: begin
        if (in_fire) begin
          id_nxt   = in_data.item_id;
          arow_nxt = in_row;
        end
      end
      CMD_PUSH: begin
        emit = 1'b1;
        if (id_ok && !present) begin
          bm_we    = 1'b1;
          bm_wdata = bm_rdata | id_mask;
          os_we    = (order_r != ORD_UNORDERED);
          cnt_nxt  = cnt_r + CW'(1);
          out_nxt.inserted = 1'b1;
        end
      end
      CMD_POP_EMPTY: begin
        emit = 1'b1;
        out_nxt.empty_pop_error = 1'b1;
      end
      CMD_POP_FETCH: begin
        id_nxt   = os_rdata;
        arow_nxt = os_row;
      end
      CMD_POP_COMMIT: begin
        emit     = 1'b1;
        bm_we    = 1'b1;
        bm_wdata = bm_rdata & ~id_mask;
        cnt_nxt  = cnt_r - CW'(1);
        if (order_r == ORD_FIFO) head_nxt = head_adv;
        out_nxt.popped_valid = 1'b1;
        out_nxt.popped_id    = id_r;
      end
      CMD_SCAN_START, CMD_RB_START: begin
        arow_nxt = '0;
        if (cmd == CMD_RB_START) begin
          wptr_nxt = '0;
          head_nxt = '0;
        end
      end
      CMD_SCAN_NEXT, CMD_RB_NEXT: arow_nxt = arow_r + RW'(1);
      CMD_SCAN_COMMIT: begin
        emit     = 1'b1;
        bm_we    = 1'b1;
        bm_wdata = bm_rdata & ~(WORD_W'(1) << scan_bit);
        cnt_nxt  = cnt_r - CW'(1);
        out_nxt.popped_valid = 1'b1;
        out_nxt.popped_id    = IDW'((32'(arow_r) << WB) | 32'(scan_bit));
      end
      CMD_CHANGE: begin
        emit = 1'b1;
        if (kind_r == KIND_CHANGE && req_ok && req_r != order_r) begin
          // unordered to ordered never lands here: that path rebuilds
          if (req_r == ORD_UNORDERED) head_nxt = '0;
          order_nxt = order_t'(req_r);
        end
      end
      CMD_RB_LOAD: word_nxt = bm_rdata;
      CMD_RB_WRITE: begin
        os_we    = 1'b1;
        os_waddr = wptr_r;
        os_wdata = IDW'((32'(arow_r) << WB) | 32'(rb_bit));
        wptr_nxt = wptr_r + IW'(1);
        word_nxt = word_r & ~(WORD_W'(1) << rb_bit);
      end
      CMD_RB_FINISH: begin
        emit      = 1'b1;
        order_nxt = order_t'(req_r);
      end
      default: ;
    endcase
    out_nxt.has_next = (cnt_nxt != '0);
    out_valid_nxt = emit ? 1'b1 : (out_ready ? 1'b0 : out_valid_r);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      arow_r      <= '0;
      head_r      <= '0;
      cnt_r       <= '0;
      order_r     <= ORD_FIFO;
      out_valid_r <= 1'b0;
    end else begin
      arow_r      <= arow_nxt;
      head_r      <= head_nxt;
      cnt_r       <= cnt_nxt;
      order_r     <= order_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      kind_r <= in_data.kind;
      req_r  <= in_data.new_order;
    end
    id_r   <= id_nxt;
    wptr_r <= wptr_nxt;
    word_r <= word_nxt;
    if (emit) out_r <= out_nxt;
  end

  dqe_ram #(.W(WORD_W), .D(ROWS)) u_bitmap (
    .clk   (clk),
    .we    (bm_we),
    .waddr (arow_r),
    .wdata (bm_wdata),
    .raddr (arow_nxt),
    .rdata (bm_rdata)
  );

  dqe_ram #(.W(IDW), .D(ID_COUNT)) u_order (
    .clk   (clk),
    .we    (os_we),
    .waddr (os_waddr),
    .wdata (os_wdata),
    .raddr (os_raddr),
    .rdata (os_rdata)
  );

  assign st.kind      = kind_r;
  assign st.in_fire   = in_fire;
  assign st.cnt_zero  = (cnt_r == '0);
  assign st.unordered = (order_r == ORD_UNORDERED);
  assign st.rebuild   = (kind_r == KIND_CHANGE) && (order_r == ORD_UNORDERED)
                        && ((req_r == ORD_FIFO) || (req_r == ORD_LIFO));
  assign st.row_hit   = (bm_rdata != '0);
  assign st.word_zero = (word_r == '0);
  assign st.last_row  = (arow_r == RW'(ROWS - 1));
  assign st.out_free  = out_free;

  assign out_valid = out_valid_r;
  assign out_data  = out_r;

`ifndef ASSERT_OFF
  a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
    32'(cnt_r) <= ID_COUNT)
    else $error("waiting count above id count");

  a_scan_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd == CMD_SCAN_NEXT) |-> !st.last_row)
    else $error("bitmap scan ran past last row with ids waiting");

  a_err_clean: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_r.empty_pop_error) |-> (!out_r.popped_valid && !out_r.has_next))
    else $error("empty pop result carries a popped id or waiting ids");

  a_pop_dec: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd == CMD_POP_COMMIT || cmd == CMD_SCAN_COMMIT) |=> (cnt_r == $past(cnt_r) - CW'(1)))
    else $error("pop did not decrement waiting count");
`endif

endmodule

@@ rtl/dedup_exploration_queue_core.sv @@
// channel | ports                          | item
// --------+--------------------------------+-------------------------------------
// input   | in_valid, in_ready, in_data    | kind, item_id, new_order
// result  | out_valid, out_ready, out_data | inserted, popped_valid, popped_id,
//         |                                | empty_pop_error, has_next
//
// One item at a time. FIFO/LIFO pop: deque read, then bitmap row read-modify-write.
// Unordered pop: scans bitmap rows until the first nonzero 32-bit row. Unordered to
// FIFO/LIFO: rebuilds the deque from the bitmap, one deque write per id. After reset a
// clearing pass zeroes the bitmap, one row a cycle, with in_ready low. A stalled result
// holds the last step of the next item; an item is taken while a result waits.
module dedup_exploration_queue_core
  import dqe_pkg::*;
#(
  parameter int ID_COUNT = ID_COUNT_DEF
) (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  output logic      in_ready,
  input  in_item_t  in_data,
  output logic      out_valid,
  input  logic      out_ready,
  output out_item_t out_data
);

  cmd_t        cmd;
  dqe_status_t st;

  // sequence each item: accept, decode, scan or rebuild, emit
  dqe_ctrl u_ctrl (
    .clk   (clk),
    .rst_n (rst_n),
    .st    (st),
    .cmd   (cmd)
  );

  // hold bitmap, deque, pointers and the result register
  dqe_datapath #(.ID_COUNT(ID_COUNT)) u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .cmd       (cmd),
    .st        (st),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

endmodule

@@ dv/dedup_exploration_queue_core_tb.sv @@
module dedup_exploration_queue_core_tb;
  import dqe_pkg::*;

  localparam int NIDS      = 1024;
  localparam int EXP_DEPTH = 64;

  logic      clk;
  logic      rst_n;
  logic      in_valid;
  logic      in_ready;
  in_item_t  in_data;
  logic      out_valid;
  logic      out_ready;
  out_item_t out_data;

  dedup_exploration_queue_core uut (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_ready(in_ready), .in_data(in_data),
    .out_valid(out_valid), .out_ready(out_ready), .out_data(out_data)
  );

  // Shadow copy of the queue: membership, deque ring, head, count, order.
  logic             waiting_set [NIDS];
  logic [IDW-1:0]   ring [NIDS];
  int unsigned      ring_head;
  int unsigned      queued;
  order_t           cur_order;

  // Expected results in acceptance order, as a ring with write and read counts.
  out_item_t        expected_q [EXP_DEPTH];
  int unsigned      exp_wr;
  int unsigned      exp_rd;
  int               errors;
  bit               hold_results;  // long receiver hold-off while set
  int               hold_cycles;

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  initial begin
    #4000000;
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

  // Advance the shadow queue by one item and return the result it should give.
  function automatic out_item_t queue_step(in_item_t it);
    out_item_t r;
    int unsigned got;
    r = '0;
    if (it.kind == KIND_PUSH) begin
      if (!waiting_set[it.item_id]) begin
        waiting_set[it.item_id] = 1'b1;
        if (cur_order != ORD_UNORDERED) ring[(ring_head + queued) % NIDS] = it.item_id;
        queued++;
        r.inserted = 1'b1;
      end
    end else if (it.kind == KIND_POP) begin
      if (queued == 0) begin
        r.empty_pop_error = 1'b1;
      end else begin
        got = 0;
        if (cur_order == ORD_UNORDERED) begin
          for (int i = NIDS - 1; i >= 0; i--) if (waiting_set[i]) got = i;
        end else if (cur_order == ORD_LIFO) begin
          got = ring[(ring_head + queued - 1) % NIDS];
        end else begin
          got = ring[ring_head];
          ring_head = (ring_head + 1) % NIDS;
        end
        waiting_set[got] = 1'b0;
        queued--;
        r.popped_valid = 1'b1;
        r.popped_id = IDW'(got);
      end
    end else if (it.kind == KIND_CHANGE) begin
      if (it.new_order <= ORD_LIFO && it.new_order != cur_order) begin
        if (it.new_order == ORD_UNORDERED) begin
          ring_head = 0;
        end else if (cur_order == ORD_UNORDERED) begin
          int unsigned n;
          n = 0;
          ring_head = 0;
          for (int i = 0; i < NIDS; i++) if (waiting_set[i]) begin
            ring[n] = IDW'(i);
            n++;
          end
        end
        cur_order = order_t'(it.new_order);
      end
    end
    r.has_next = (queued != 0);
    return r;
  endfunction

  // Send one item after a random gap; predict the result on acceptance.
  task automatic send_item(logic [1:0] kind, logic [IDW-1:0] id, logic [1:0] ord,
                           bit no_gap = 0);
    in_item_t it;
    int gap;
    it.kind = kind;
    it.item_id = id;
    it.new_order = ord;
    gap = no_gap ? 0 : $urandom_range(0, 5);
    if ($urandom_range(0, 3) == 0) gap = 0;
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= it;
    do @(posedge clk); while (!in_ready);
    expected_q[exp_wr % EXP_DEPTH] = queue_step(it);
    exp_wr++;
    @(negedge clk);
  endtask

  task automatic drain();
    int guard;
    guard = 0;
    in_valid <= 1'b0;
    while (exp_wr != exp_rd && guard < 200000) begin
      @(negedge clk);
      guard++;
    end
    repeat (4) @(negedge clk);  // let the last handshake settle
  endtask

  // Receiver: draw a wait after each accepted result, or hold off when requested.
  initial begin : receiver
    int wait_left;
    bit took;
    out_ready = 1'b0;
    wait_left = 0;
    @(posedge rst_n);
    forever begin
      @(posedge clk);
      took = out_valid && out_ready;
      @(negedge clk);
      if (took) wait_left = $urandom_range(0, 5);
      if (hold_results) begin
        out_ready <= 1'b0;
        hold_cycles++;
      end else if (wait_left > 0) begin
        out_ready <= 1'b0;
        wait_left--;
      end else begin
        out_ready <= 1'b1;
      end
    end
  end

  // Checker: compare each accepted result with the oldest prediction.
  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready) begin
      if (exp_wr == exp_rd) begin
        $error("unexpected result %p", out_data);
        errors++;
      end else begin
        out_item_t e;
        e = expected_q[exp_rd % EXP_DEPTH];
        exp_rd++;
        if (out_data.inserted !== e.inserted) begin
          $error("inserted exp %0d got %0d", e.inserted, out_data.inserted); errors++;
        end
        if (out_data.popped_valid !== e.popped_valid) begin
          $error("popped_valid exp %0d got %0d", e.popped_valid, out_data.popped_valid);
          errors++;
        end
        if (out_data.popped_id !== e.popped_id) begin
          $error("popped_id exp %0d got %0d", e.popped_id, out_data.popped_id); errors++;
        end
        if (out_data.empty_pop_error !== e.empty_pop_error) begin
          $error("empty_pop_error exp %0d got %0d", e.empty_pop_error,
                 out_data.empty_pop_error);
          errors++;
        end
        if (out_data.has_next !== e.has_next) begin
          $error("has_next exp %0d got %0d", e.has_next, out_data.has_next); errors++;
        end
      end
    end
  end

  // Extremes, duplicates, empty pops, order changes and the odd codes.
  task automatic test_directed();
    send_item(KIND_POP, '0, '0);
    send_item(KIND_PUSH, 10'd0, '0);
    send_item(KIND_PUSH, 10'd1023, '0);
    send_item(KIND_PUSH, 10'd0, '0);          // duplicate
    send_item(KIND_PUSH, 10'd512, 2'd3);
    send_item(KIND_CHANGE, 10'h3ff, ORD_LIFO);
    send_item(KIND_POP, 10'h3ff, 2'd3);
    send_item(KIND_CHANGE, '0, ORD_UNORDERED);
    send_item(KIND_PUSH, 10'd700, '0);
    send_item(KIND_POP, '0, '0);
    send_item(KIND_CHANGE, '0, 2'd3);         // unknown order code
    send_item(2'd3, 10'h2aa, ORD_FIFO);       // unknown kind
    send_item(KIND_CHANGE, '0, ORD_FIFO);     // rebuild from bitmap
    send_item(KIND_POP, '0, '0);
    send_item(KIND_CHANGE, '0, ORD_FIFO);     // same order
    send_item(KIND_POP, '0, '0);
    send_item(KIND_POP, '0, '0);
    send_item(KIND_PUSH, 10'h155, '0);
    send_item(KIND_CHANGE, '0, ORD_UNORDERED);
    send_item(KIND_CHANGE, '0, ORD_LIFO);
    send_item(KIND_POP, '0, '0);
    drain();
  endtask

  // Long receiver hold-off while pushes keep coming, so the input stalls.
  task automatic test_backpressure();
    hold_cycles = 0;
    hold_results = 1'b1;
    fork
      begin
        for (int i = 0; i < 20; i++) send_item(KIND_PUSH, IDW'($urandom), '0, 1);
      end
      begin
        while (hold_cycles < 300) @(negedge clk);
        hold_results = 1'b0;
      end
    join
    drain();
  endtask

  // Random work: mostly push/pop bursts under each order, with order switches.
  task automatic test_random(int count);
    int k;
    logic [IDW-1:0] id;
    for (int n = 0; n < count; n++) begin
      k = $urandom_range(0, 99);
      id = ($urandom_range(0, 3) == 0) ? IDW'($urandom_range(0, 15)) : IDW'($urandom);
      if (k < 50) send_item(KIND_PUSH, id, 2'($urandom));
      else if (k < 92) send_item(KIND_POP, IDW'($urandom), 2'($urandom));
      else if (k < 98) send_item(KIND_CHANGE, IDW'($urandom), 2'($urandom_range(0, 3)));
      else send_item(2'd3, IDW'($urandom), 2'($urandom));
      if (n % 400 == 399) drain();  // sender pauses until all results are back
    end
    drain();
  endtask

  initial begin
    errors = 0;
    hold_results = 1'b0;
    hold_cycles = 0;
    exp_wr = 0;
    exp_rd = 0;
    rst_n = 1'b0;
    in_valid = 1'b0;
    in_data = '0;
    for (int i = 0; i < NIDS; i++) begin
      waiting_set[i] = 1'b0;
      ring[i] = '0;
    end
    ring_head = 0;
    queued = 0;
    cur_order = ORD_FIFO;
    repeat (8) @(negedge clk);
    rst_n = 1'b1;
    test_directed();
    test_backpressure();
    test_random(1700);
    if (errors == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule
